FILE: hw/rtl/spct_pkg.sv
// package for the sweep and prune collision table: sizes, codes and types
package spct_pkg;
  localparam int MaxBoxes  = 64;
  localparam int UnitScale = 256;
  localparam int SlotW     = $clog2(MaxBoxes);
  localparam int CountW    = $clog2(MaxBoxes + 1);
  localparam int IdW       = 6;
  localparam int IdCount   = 64;
  localparam int ScaleW    = $clog2(UnitScale) + 1;
  localparam int ExtW      = 16 + ScaleW;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_MOVE   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_IN_USE = 2'd3
  } status_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [7:0]     owner_kind;
    logic [15:0]    size_h;
    logic [15:0]    size_w;
    logic [31:0]    pos_y;
    logic [31:0]    pos_x;
    logic [IdW-1:0] box_id;
    logic [1:0]     op;
  } cmd_t;

  typedef struct packed {
    logic [1:0]     status;
    logic           hit_valid;
    logic [IdW-1:0] hit_id;
    logic [7:0]     hitter_kind;
    logic           last;
  } res_t;

  function automatic logic [ExtW-1:0] scale_size(input logic [15:0] s);
    logic [ExtW-1:0] r;
    r = ExtW'(s) * ExtW'(UnitScale);
    return r;
  endfunction
endpackage

FILE: hw/rtl/sweep_prune_collision_table.sv
// sweep and prune broadphase table: sorted x and y arrays in memories, sequenced updates
//
// channel  dir  beat contents
// s_axis   in   tdata: op, box_id, pos_x, pos_y, size_w, size_h, owner_kind
// m_axis   out  tdata: status, hit_valid, hit_id, hitter_kind; tlast: last
//
// one command at a time; the id lookup (S_LOOK, S_DEC) follows once the input beat is taken
// insert and move: each axis bubbles the entry slot by slot (S_BUB_RD, S_BUB_CMP), then
// writes it (S_BUB_FIN); remove: later slots shift down one by one on each axis; query:
// fetch the box, then check each swept x neighbour in order for y overlap
// reset empties the table at once through live bits and the entry count
// a result waiting on m_axis holds the sequencer; s_axis_tready is high only when idle
module sweep_prune_collision_table
  import spct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], box_id[7:2], pos_x[39:8], pos_y[71:40], size_w[87:72],
  // size_h[103:88], owner_kind[111:104]
  input  logic [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], hit_valid[2], hit_id[8:3], hitter_kind[16:9], zero[23:17]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOOK, S_DEC,
    S_BUB_RD, S_BUB_CMP, S_BUB_FIN, S_AX_NEXT,
    S_RM_RD, S_RM_WR,
    S_Q_XRD, S_Q_YRD, S_Q_BASE, S_Q_NX, S_Q_NX_X, S_Q_NX_S, S_Q_CHK, S_Q_END,
    S_OUT
  } state_t;

  // memories
  logic signed [31:0] xk_mem [MaxBoxes];
  logic [IdW-1:0]     xl_mem [MaxBoxes];
  logic signed [31:0] yk_mem [MaxBoxes];
  logic [IdW-1:0]     yl_mem [MaxBoxes];
  logic [SlotW-1:0]   xs_mem [IdCount];
  logic [SlotW-1:0]   ys_mem [IdCount];
  logic [2*ExtW-1:0]  ext_mem [IdCount];
  logic [7:0]         kind_mem [IdCount];
  logic [IdCount-1:0] live;
  logic [CountW-1:0]  count;

  state_t state;
  cmd_t   cmd;
  logic   axis;          // 0 x, 1 y
  logic   dir_down;
  logic [SlotW-1:0] i;
  logic [SlotW-1:0] ysl;
  logic signed [31:0] ka;
  logic [IdW-1:0] la;
  logic signed [33:0] top_x, ty, top_y;
  logic [IdW-1:0] other;
  logic [5:0] nhits;
  logic [7:0] qkind;
  logic [ExtW-1:0] qw, qh;
  res_t res;
  res_t pend;
  logic have_pend;

  // memory read data
  logic signed [31:0] rxk, ryk;
  logic [IdW-1:0] rxl, ryl;
  logic [SlotW-1:0] rxs, rys;
  logic [2*ExtW-1:0] rext;
  logic [7:0] rkind;

  // memory addresses and write controls
  logic [SlotW-1:0] ra;
  logic [IdW-1:0] ida;
  logic kwe, swe, ext_we;
  logic signed [31:0] kwk;
  logic [IdW-1:0] kwl, swa;

  logic signed [31:0] nk;
  logic [IdW-1:0] nl;
  logic [CountW-1:0] ip1;
  logic [SlotW-1:0] inext, nidx;
  logic swap;

  function automatic res_t done_res(input status_t st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {7'd0, res.hitter_kind, res.hit_id, res.hit_valid, res.status};
  assign m_axis_tlast  = res.last;

  assign nk    = axis ? ryk : rxk;
  assign nl    = axis ? ryl : rxl;
  assign ip1   = CountW'(i) + CountW'(1);
  assign inext = ip1[SlotW-1:0];
  assign nidx  = dir_down ? i - 1'b1 : inext;
  assign swap  = dir_down ? (ka < nk) : (ka > nk);
  assign ext_we = (state == S_DEC) && (cmd.op == OP_INSERT) && !live[cmd.box_id];

  always_comb begin
    ra = i; ida = cmd.box_id;
    kwe = 1'b0; kwk = nk; kwl = nl;
    swe = 1'b0; swa = nl;
    unique case (state)
      S_BUB_RD: ra = nidx;
      S_BUB_CMP: begin
        // neighbor moves into slot i when out of order
        if (swap) begin
          kwe = 1'b1; swe = 1'b1;
        end
      end
      S_BUB_FIN: begin
        kwe = 1'b1; kwk = ka; kwl = la;
        swe = 1'b1; swa = la;
      end
      S_RM_RD: ra = inext;
      S_RM_WR: begin
        kwe = 1'b1; swe = 1'b1;
      end
      S_Q_YRD: ra = ysl;
      S_Q_NX: ra = inext;
      S_Q_NX_X: ida = rxl;
      S_Q_NX_S: ra = rys;
      default: ;
    endcase
  end

  // reads, registered; memory writes
  always_ff @(posedge clk) begin
    rxk   <= xk_mem[ra];
    rxl   <= xl_mem[ra];
    ryk   <= yk_mem[ra];
    ryl   <= yl_mem[ra];
    rxs   <= xs_mem[ida];
    rys   <= ys_mem[ida];
    rext  <= ext_mem[ida];
    rkind <= kind_mem[ida];
    if (kwe) begin
      if (axis) begin
        yk_mem[i] <= kwk; yl_mem[i] <= kwl;
      end else begin
        xk_mem[i] <= kwk; xl_mem[i] <= kwl;
      end
    end
    if (swe) begin
      if (axis) ys_mem[swa] <= i;
      else xs_mem[swa] <= i;
    end
    if (ext_we) begin
      ext_mem[cmd.box_id]  <= {scale_size(cmd.size_h), scale_size(cmd.size_w)};
      kind_mem[cmd.box_id] <= cmd.owner_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      count     <= '0;
      axis      <= 1'b0;
      dir_down  <= 1'b0;
      have_pend <= 1'b0;
      res       <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cmd   <= cmd_t'(s_axis_tdata);
          state <= S_LOOK;
        end
        S_LOOK: state <= S_DEC;
        S_DEC: begin
          axis      <= 1'b0;
          dir_down  <= 1'b0;
          have_pend <= 1'b0;
          nhits     <= '0;
          ka        <= cmd.pos_x;
          la        <= cmd.box_id;
          qkind     <= rkind;
          qw        <= rext[ExtW-1:0];
          qh        <= rext[2*ExtW-1:ExtW];
          if (cmd.op == OP_INSERT) begin
            if (live[cmd.box_id]) begin
              res <= done_res(ST_IN_USE); state <= S_OUT;
            end else if (count >= CountW'(MaxBoxes)) begin
              res <= done_res(ST_FULL); state <= S_OUT;
            end else begin
              live[cmd.box_id] <= 1'b1;
              count <= count + 1'b1;
              i     <= count[SlotW-1:0];
              ysl   <= count[SlotW-1:0];
              state <= S_BUB_RD;
            end
          end else if (!live[cmd.box_id]) begin
            res <= done_res(ST_UNKNOWN); state <= S_OUT;
          end else begin
            i   <= rxs;
            ysl <= rys;
            if (cmd.op == OP_QUERY) state <= S_Q_XRD;
            else if (cmd.op == OP_REMOVE) state <= S_RM_RD;
            else state <= S_BUB_RD;
          end
        end
        S_BUB_RD: begin
          if (!dir_down && ip1 < count) state <= S_BUB_CMP;
          else if (!dir_down) dir_down <= 1'b1;
          else if (i != '0) state <= S_BUB_CMP;
          else state <= S_BUB_FIN;
        end
        S_BUB_CMP: begin
          if (swap) begin
            i <= nidx; state <= S_BUB_RD;
          end else if (!dir_down) begin
            dir_down <= 1'b1; state <= S_BUB_RD;
          end else state <= S_BUB_FIN;
        end
        S_BUB_FIN: state <= S_AX_NEXT;
        S_AX_NEXT: begin
          if (!axis) begin
            axis     <= 1'b1;
            i        <= ysl;
            dir_down <= 1'b0;
            ka       <= cmd.pos_y;
            if (cmd.op == OP_REMOVE) state <= S_RM_RD;
            else state <= S_BUB_RD;
          end else begin
            if (cmd.op == OP_REMOVE) begin
              count <= count - 1'b1;
              live[cmd.box_id] <= 1'b0;
            end
            res   <= done_res(ST_OK);
            state <= S_OUT;
          end
        end
        S_RM_RD: begin
          if (ip1 < count) state <= S_RM_WR;
          else state <= S_AX_NEXT;
        end
        S_RM_WR: begin
          i <= inext; state <= S_RM_RD;
        end
        S_Q_XRD: state <= S_Q_YRD;
        S_Q_YRD: begin
          top_x <= 34'(rxk) + 34'(qw);
          state <= S_Q_BASE;
        end
        S_Q_BASE: begin
          ty    <= 34'(ryk);
          top_y <= 34'(ryk) + 34'(qh);
          state <= S_Q_NX;
        end
        S_Q_NX: begin
          if (ip1 < count) state <= S_Q_NX_X;
          else state <= S_Q_END;
        end
        S_Q_NX_X: begin
          if (34'(rxk) > top_x) state <= S_Q_END;
          else begin
            other <= rxl; state <= S_Q_NX_S;
          end
        end
        S_Q_NX_S: state <= S_Q_CHK;
        S_Q_CHK: begin
          i <= inext;
          if (34'(ryk) <= top_y && 34'(ryk) >= ty && nhits != 6'd63) begin
            nhits     <= nhits + 1'b1;
            pend      <= '{status: ST_OK, hit_valid: 1'b1, hit_id: other,
                           hitter_kind: qkind, last: 1'b0};
            have_pend <= 1'b1;
            // a newer hit means the held one is not the last
            if (have_pend) begin
              res <= pend; state <= S_OUT;
            end else state <= S_Q_NX;
          end else state <= S_Q_NX;
        end
        S_Q_END: begin
          if (have_pend) begin
            res <= '{status: ST_OK, hit_valid: 1'b1, hit_id: pend.hit_id,
                     hitter_kind: pend.hitter_kind, last: 1'b1};
          end else res <= done_res(ST_OK);
          have_pend <= 1'b0;
          state     <= S_OUT;
        end
        S_OUT: if (m_axis_tready) begin
          if (res.last) state <= S_IDLE;
          else state <= S_Q_NX;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MaxBoxes)) else $error("entry count over capacity");

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepting while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while busy");

  a_nohit_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tlast)
    else $error("non-hit beat without last");

endmodule
